[hdl/assert_macros.svh]
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/wsfpe_pkg.sv]
// Types and constants shared by the pulse encoder modules.
package wsfpe_pkg;

  localparam int TICK_W        = 15;
  localparam int COLOR_W       = 8;
  localparam int IDX_W         = 2;
  localparam int BITS_PER_LED  = 24;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_LED);
  localparam int LED_TOTAL_DEF = 2;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = TICK_W'(16);
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = TICK_W'(34);
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = TICK_W'(32);
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = TICK_W'(18);

  // register index = paddr[3:2]
  localparam logic [1:0] REG_ZERO_HIGH = 2'd0;
  localparam logic [1:0] REG_ZERO_LOW  = 2'd1;
  localparam logic [1:0] REG_ONE_HIGH  = 2'd2;
  localparam logic [1:0] REG_ONE_LOW   = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic store_we;  // write the accepted colour into the store
    logic start;     // rewind the bit sequencer to LED 0, bit 23
    logic step;      // load one pulse into the output register, advance
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;   // accepted LED index is below the LED count
    logic final_bit;  // sequencer sits on the last bit of the frame
    logic out_free;   // output register empty or being taken
  } sts_t;

endpackage

[hdl/ws2812_frame_pulse_encoder.sv]
// Top level of the WS2812 frame pulse encoder.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+--------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: led_index, red, green, blue
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: high_ticks, low_ticks; tlast
//  apb       | in  | psel, penable, pready (=1)    | four 15-bit tick registers
//
// Flow: a colour request is taken while the sequencer is idle; the bit sequencer
//   then loads one pulse per cycle into the output register while the sink is ready.
// A request whose LED index is at or above LED_TOTAL is taken and dropped.
// Reset (rst, synchronous): colour store cleared to zero, tick registers to defaults.
// Stalls: m_axis_tready low holds the output register and the sequencer; the next
//   request may be taken while the final pulse still waits in the output register.
module ws2812_frame_pulse_encoder #(
  parameter int LED_TOTAL = wsfpe_pkg::LED_TOTAL_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // colour request
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] led_index, [9:2] red, [17:10] green, [25:18] blue, [31:26] zero
  input  logic [31:0]                     s_axis_tdata,
  // pulse output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [14:0] high_ticks, [29:15] low_ticks, [31:30] zero
  output logic [31:0]                     m_axis_tdata,
  output logic                            m_axis_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wsfpe_pkg::ADDR_W-1:0]    paddr,
  input  logic [wsfpe_pkg::DATA_W-1:0]    pwdata,
  output logic [wsfpe_pkg::DATA_W-1:0]    prdata,
  output logic                            pready
);
  import wsfpe_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  logic [TICK_W-1:0] high_ticks;
  logic [TICK_W-1:0] low_ticks;

  assign pready = 1'b1;

  wsfpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  wsfpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wsfpe_dpath #(
    .LED_TOTAL (LED_TOTAL)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .led_index  (s_axis_tdata[1:0]),
    .red        (s_axis_tdata[9:2]),
    .green      (s_axis_tdata[17:10]),
    .blue       (s_axis_tdata[25:18]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .high_ticks (high_ticks),
    .low_ticks  (low_ticks),
    .last       (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, low_ticks, high_ticks};

endmodule

[hdl/wsfpe_regs.sv]
// Timing registers behind the APB-style configuration port.
module wsfpe_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wsfpe_pkg::ADDR_W-1:0]   paddr,
  input  logic [wsfpe_pkg::DATA_W-1:0]   pwdata,
  output logic [wsfpe_pkg::DATA_W-1:0]   prdata,
  output wsfpe_pkg::cfg_t                cfg
);
  import wsfpe_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zero_high <= ZERO_HIGH_RST;
      cfg.zero_low  <= ZERO_LOW_RST;
      cfg.one_high  <= ONE_HIGH_RST;
      cfg.one_low   <= ONE_LOW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ZERO_HIGH: cfg.zero_high <= pwdata[TICK_W-1:0];
        REG_ZERO_LOW:  cfg.zero_low  <= pwdata[TICK_W-1:0];
        REG_ONE_HIGH:  cfg.one_high  <= pwdata[TICK_W-1:0];
        REG_ONE_LOW:   cfg.one_low   <= pwdata[TICK_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ZERO_HIGH: prdata = DATA_W'(cfg.zero_high);
      REG_ZERO_LOW:  prdata = DATA_W'(cfg.zero_low);
      REG_ONE_HIGH:  prdata = DATA_W'(cfg.one_high);
      REG_ONE_LOW:   prdata = DATA_W'(cfg.one_low);
      default:       prdata = '0;
    endcase
  end

endmodule

[hdl/wsfpe_ctrl.sv]
// Controller: accepts a colour request and sequences one frame of pulses.
`include "assert_macros.svh"

module wsfpe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  wsfpe_pkg::sts_t  sts,
  output wsfpe_pkg::cmd_t  cmd
);
  import wsfpe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.store_we = 1'b0;
    cmd.start    = 1'b0;
    cmd.step     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // out-of-range index: request is taken and dropped
        if (in_valid && sts.in_range) begin
          cmd.store_we = 1'b1;
          cmd.start    = 1'b1;
          state_next   = ST_SEND;
        end
      end
      ST_SEND: begin
        cmd.step = sts.out_free;
        if (sts.out_free && sts.final_bit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_frame_ends, clk, rst, (state == ST_SEND && sts.out_free && sts.final_bit), (state == ST_IDLE))
  `ASSERT_IMPL(a_no_step_idle, clk, rst, (state == ST_IDLE), (!cmd.step))
  `ASSERT_NEXT(a_start_sends, clk, rst, (cmd.start), (state == ST_SEND && !in_ready))

endmodule

[hdl/wsfpe_dpath.sv]
// Datapath: colour store, bit sequencer and output pulse register.
`include "assert_macros.svh"

module wsfpe_dpath #(
  parameter int LED_TOTAL = wsfpe_pkg::LED_TOTAL_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  wsfpe_pkg::cmd_t                   cmd,
  output wsfpe_pkg::sts_t                   sts,
  input  wsfpe_pkg::cfg_t                   cfg,
  input  logic [wsfpe_pkg::IDX_W-1:0]       led_index,
  input  logic [wsfpe_pkg::COLOR_W-1:0]     red,
  input  logic [wsfpe_pkg::COLOR_W-1:0]     green,
  input  logic [wsfpe_pkg::COLOR_W-1:0]     blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [wsfpe_pkg::TICK_W-1:0]      high_ticks,
  output logic [wsfpe_pkg::TICK_W-1:0]      low_ticks,
  output logic                              last
);
  import wsfpe_pkg::*;

  localparam int LED_W = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
  localparam logic [BIT_CNT_W-1:0] BIT_TOP  = BIT_CNT_W'(BITS_PER_LED - 1);
  localparam logic [LED_W-1:0]     LED_LAST = LED_W'(LED_TOTAL - 1);

  // packed G[23:16] R[15:8] B[7:0], sent MSB first
  logic [BITS_PER_LED-1:0] store [LED_TOTAL];
  logic [LED_W-1:0]        led_cnt;
  logic [BIT_CNT_W-1:0]    bit_cnt;
  logic [BITS_PER_LED-1:0] word;
  logic                    cur_bit;

  assign word    = store[led_cnt];
  assign cur_bit = word[bit_cnt];

  assign sts.in_range  = (int'(led_index) < LED_TOTAL);
  assign sts.final_bit = (led_cnt == LED_LAST) && (bit_cnt == '0);
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LED_TOTAL; i++) begin
        store[i] <= '0;
      end
    end else if (cmd.store_we) begin
      store[led_index[LED_W-1:0]] <= {green, red, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_cnt <= '0;
      bit_cnt <= BIT_TOP;
    end else if (cmd.start) begin
      led_cnt <= '0;
      bit_cnt <= BIT_TOP;
    end else if (cmd.step) begin
      if (bit_cnt == '0) begin
        bit_cnt <= BIT_TOP;
        led_cnt <= led_cnt + LED_W'(1);
      end else begin
        bit_cnt <= bit_cnt - BIT_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      high_ticks <= cur_bit ? cfg.one_high : cfg.zero_high;
      low_ticks  <= cur_bit ? cfg.one_low  : cfg.zero_low;
      last       <= sts.final_bit;
    end
  end

  `ASSERT_NEXT(a_start_rewinds, clk, rst, (cmd.start), (bit_cnt == BIT_TOP && led_cnt == '0))
  `ASSERT_NEXT(a_last_marked, clk, rst, (cmd.step && sts.final_bit), (out_valid && last))
  `ASSERT_NEXT(a_not_last, clk, rst, (cmd.step && !sts.final_bit), (out_valid && !last))

endmodule

[tb/tb_ws2812_frame_pulse_encoder.sv]
// Self-checking testbench for the WS2812 frame pulse encoder.
module tb_ws2812_frame_pulse_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfpe_pkg::*;

  localparam int LEDS        = LED_TOTAL_DEF;
  localparam int FRAME_BITS  = LEDS * BITS_PER_LED;
  // wait after the last owed pulse before the tick registers are rewritten
  localparam int SETTLE_CYC  = FRAME_BITS + 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_REQS  = 52;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [IDX_W-1:0]   led_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } colour_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] low_ticks;
    logic              last;
  } pulse_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              m_axis_tlast;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ws2812_frame_pulse_encoder #(
    .LED_TOTAL(LEDS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow state: colour store and tick registers as the block should hold them
  // ---------------------------------------------------------------------------
  logic [BITS_PER_LED-1:0] led_grb [LEDS];
  cfg_t                    tick_cfg;

  colour_req_t colour_req_q [$];  // requests waiting for the driver
  pulse_t      pulse_expect [$];  // pulses the block still owes us

  int  reqs_queued   = 0;
  int  reqs_accepted = 0;
  int  frames_due    = 0;
  int  pulses_seen   = 0;
  int  dropped_reqs  = 0;
  int  cfg_writes    = 0;
  int  err_n         = 0;
  int  cycle_n       = 0;
  bit  quiet_tail    = 1'b0;  // no idling on either side once set
  int  gap_left      = 0;
  int  stall_left    = 0;

  // Store the colour, then queue the pulses of the whole chain, LED 0 first,
  // G R B order, MSB first. Out-of-range index: nothing changes, nothing owed.
  function automatic void encode_frame(colour_req_t req);
    logic   one;
    pulse_t p;
    if (int'(req.led_index) >= LEDS) begin
      dropped_reqs++;
      return;
    end
    led_grb[req.led_index] = {req.green, req.red, req.blue};
    for (int led = 0; led < LEDS; led++) begin
      for (int b = BITS_PER_LED - 1; b >= 0; b--) begin
        one          = led_grb[led][b];
        p.high_ticks = one ? tick_cfg.one_high : tick_cfg.zero_high;
        p.low_ticks  = one ? tick_cfg.one_low  : tick_cfg.zero_low;
        p.last       = (led == LEDS - 1) && (b == 0);
        pulse_expect.push_back(p);
      end
    end
    frames_due++;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: holds tdata/tvalid until taken, inserts random idle cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    colour_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !s_axis_tready) begin
      // request still pending, keep it on the bus
    end else if (gap_left > 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left--;
    end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap_left = $urandom_range(0, 2);
    end else if (colour_req_q.size() != 0) begin
      req = colour_req_q.pop_front();
      s_axis_tdata  <= {6'b0, req.blue, req.green, req.red, req.led_index};
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Pulse sink: random back-pressure bursts
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each taken pulse against the oldest owed one, then predict
  // the frame for a request taken on this edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_t exp_p;
    pulse_t got_p;
    colour_req_t req;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_p.high_ticks = m_axis_tdata[TICK_W-1:0];
        got_p.low_ticks  = m_axis_tdata[2*TICK_W-1:TICK_W];
        got_p.last       = m_axis_tlast;
        if (pulse_expect.size() == 0) begin
          err_n++;
          $display("%0t: unexpected pulse, expected none, got high %0d low %0d last %0b",
                   $time, got_p.high_ticks, got_p.low_ticks, got_p.last);
        end else begin
          exp_p = pulse_expect.pop_front();
          if (got_p.high_ticks !== exp_p.high_ticks) begin
            err_n++;
            $display("%0t: pulse %0d high_ticks expected %0d got %0d",
                     $time, pulses_seen, exp_p.high_ticks, got_p.high_ticks);
          end
          if (got_p.low_ticks !== exp_p.low_ticks) begin
            err_n++;
            $display("%0t: pulse %0d low_ticks expected %0d got %0d",
                     $time, pulses_seen, exp_p.low_ticks, got_p.low_ticks);
          end
          if (got_p.last !== exp_p.last) begin
            err_n++;
            $display("%0t: pulse %0d last expected %0b got %0b",
                     $time, pulses_seen, exp_p.last, got_p.last);
          end
        end
        pulses_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.led_index = s_axis_tdata[1:0];
        req.red       = s_axis_tdata[9:2];
        req.green     = s_axis_tdata[17:10];
        req.blue      = s_axis_tdata[25:18];
        encode_frame(req);
        reqs_accepted++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("ws2812_frame_pulse_encoder verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_req(input logic [IDX_W-1:0] idx, input logic [COLOR_W-1:0] r,
                           input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    colour_req_t req;
    req.led_index = idx;
    req.red       = r;
    req.green     = g;
    req.blue      = b;
    colour_req_q.push_back(req);
    reqs_queued++;
  endtask

  // Sender pause: everything taken, every owed pulse back, then let a late
  // dropped request or a stalled last pulse clear out of the block.
  task automatic settle();
    @(negedge clk);
    while (reqs_accepted != reqs_queued || pulse_expect.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // APB write: setup, access, register loads on the access edge (pready tied high).
  // Upper bits of pwdata carry junk the block must ignore.
  task automatic apb_write(input logic [1:0] reg_idx, input logic [TICK_W-1:0] ticks);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {(DATA_W-TICK_W)'($urandom), ticks};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_ZERO_HIGH: tick_cfg.zero_high = ticks;
      REG_ZERO_LOW:  tick_cfg.zero_low  = ticks;
      REG_ONE_HIGH:  tick_cfg.one_high  = ticks;
      default:       tick_cfg.one_low   = ticks;
    endcase
    cfg_writes++;
  endtask

  task automatic program_ticks(input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
                               input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol);
    apb_write(REG_ZERO_HIGH, zh);
    apb_write(REG_ZERO_LOW,  zl);
    apb_write(REG_ONE_HIGH,  oh);
    apb_write(REG_ONE_LOW,   ol);
  endtask

  // duration for a random phase: extremes, zero, reset value or anything
  function automatic logic [TICK_W-1:0] pick_ticks(input logic [TICK_W-1:0] dflt);
    case ($urandom_range(0, 5))
      0:       return TICK_W'(1);
      1:       return TICK_MAX;
      2:       return dflt;
      3:       return '0;
      default: return TICK_W'($urandom);
    endcase
  endfunction

  // colour byte: all-off, all-on or random, so whole-byte runs show up too
  function automatic logic [COLOR_W-1:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int in_range_n;
    logic [IDX_W-1:0] idx;

    for (int i = 0; i < LEDS; i++) led_grb[i] = '0;
    tick_cfg = '{zero_high: ZERO_HIGH_RST, zero_low: ZERO_LOW_RST,
                 one_high: ONE_HIGH_RST, one_low: ONE_LOW_RST};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset timing: all-zero chain, all-on, dropped indices, bit patterns
    queue_req(2'd0, 8'h00, 8'h00, 8'h00);
    queue_req(2'd1, 8'hFF, 8'hFF, 8'hFF);
    queue_req(2'd2, 8'hFF, 8'hFF, 8'hFF);
    queue_req(2'd3, 8'hFF, 8'hFF, 8'hFF);
    queue_req(2'd0, 8'hFF, 8'h00, 8'hAA);
    queue_req(2'd1, 8'h55, 8'hAA, 8'h0F);
    queue_req(2'd0, 8'h80, 8'h01, 8'h80);
    settle();

    // zero durations and the 15-bit maximum
    program_ticks('0, TICK_MAX, TICK_MAX, '0);
    queue_req(2'd1, 8'hFF, 8'hFF, 8'hFF);
    queue_req(2'd0, 8'h00, 8'h00, 8'h00);
    queue_req(2'd1, 8'hA5, 8'h5A, 8'hC3);
    settle();

    // minimum legal durations next to the top of the range
    program_ticks(TICK_W'(1), TICK_W'(2), TICK_MAX, TICK_MAX - 1);
    queue_req(2'd0, 8'hFF, 8'hFF, 8'hFF);
    queue_req(2'd1, 8'h00, 8'h00, 8'h00);
    queue_req(2'd3, 8'h12, 8'h34, 8'h56);
    queue_req(2'd0, 8'h01, 8'h80, 8'h7E);
    settle();

    // random phases, each with its own timing; last one with no idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) begin
        program_ticks(ZERO_HIGH_RST, ZERO_LOW_RST, ONE_HIGH_RST, ONE_LOW_RST);
        quiet_tail = 1'b1;
      end else begin
        program_ticks(pick_ticks(ZERO_HIGH_RST), pick_ticks(ZERO_LOW_RST),
                      pick_ticks(ONE_HIGH_RST), pick_ticks(ONE_LOW_RST));
      end
      in_range_n = 0;
      while (in_range_n < PHASE_REQS) begin
        // mostly real colour updates, some out-of-range noise
        if ($urandom_range(0, 6) == 0) idx = IDX_W'($urandom_range(LEDS, 3));
        else idx = IDX_W'($urandom_range(0, LEDS - 1));
        if (int'(idx) < LEDS) in_range_n++;
        queue_req(idx, pick_byte(), pick_byte(), pick_byte());
      end
      settle();
    end

    $display("covered %0d requests (%0d dropped), %0d frames, %0d pulses checked",
             reqs_accepted, dropped_reqs, frames_due, pulses_seen);
    $display("%0d tick register writes over %0d timing setups, zero and max durations included",
             cfg_writes, cfg_writes / 4);
    if (err_n == 0) begin
      $display("ws2812_frame_pulse_encoder verification clean");
    end else begin
      $display("ws2812_frame_pulse_encoder verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/wsfpe_pkg.sv
hdl/wsfpe_regs.sv
hdl/wsfpe_ctrl.sv
hdl/wsfpe_dpath.sv
hdl/ws2812_frame_pulse_encoder.sv
tb/tb_ws2812_frame_pulse_encoder.sv
